@@ hdl/chacha_pkg.sv @@
// chacha_pkg: shared types, constants and helpers for the chacha20 byte cipher
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package chacha_pkg;

    localparam int DOUBLE_ROUND_COUNT = 10;
    localparam int WORD_COUNT         = 16;
    localparam int ROUND_STEPS        = 8 * DOUBLE_ROUND_COUNT;
    localparam int ROUND_CNT_W        = $clog2(ROUND_STEPS);
    localparam int CFG_DATA_W         = 64;
    localparam int CFG_INDEX_W        = 3;

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_0     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_1     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_2     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_3     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_LO  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_HI  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_CTR  = 3'd6;

    typedef logic [31:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       restart;
        logic       direct;
        logic       load_init;
        logic       round_step;
        logic       final_add;
        logic       emit;
        logic       diag;
        logic [1:0] step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic ks_valid;
    } dp_status_t;

    function automatic word_t rotl32(input word_t v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

endpackage

@@ hdl/chacha20_stream_cipher_core.sv @@
// chacha20 byte cipher: with a keystream block held, a byte's result leaves the cycle after its
// transfer and bytes follow at one per cycle while the output does not stall; a byte that starts
// a block passes the load, round, final-add and emit states first, the rounds run by the
// one-step-per-cycle quarter-round unit over four lanes; output stalls hold back both kinds of
// byte; reset clears control, counter, position and all configuration registers and leaves the
// keystream invalid
`timescale 1ns / 1ps

module chacha20_stream_cipher_core
    import chacha_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             in_byte,
    input  logic                   first_of_message,
    input  logic                   last_of_message,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   out_last
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    chacha_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .first_of_message (first_of_message),
        .out_stall        (out_stall),
        .status           (status),
        .in_stall         (in_stall),
        .out_valid        (out_valid),
        .cmd              (cmd)
    );

    chacha_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_byte         (in_byte),
        .last_of_message (last_of_message),
        .cmd             (cmd),
        .status          (status),
        .out_byte        (out_byte),
        .out_last        (out_last)
    );

`ifndef SYNTHESIS
    // a byte goes straight out only against a held block
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.direct |-> (status.ks_valid && !first_of_message))
        else $error("direct transfer without a valid keystream block");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_add |=> status.ks_valid)
        else $error("keystream not marked valid after block generation");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("generated byte did not reach the output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.direct, cmd.load_init, cmd.round_step,
                  cmd.final_add, cmd.emit}))
        else $error("conflicting datapath commands");
`endif

endmodule

@@ hdl/chacha_ctrl.sv @@
// chacha_ctrl: sequencer for transfers, block generation and the output register valid
// depends on chacha_pkg
`timescale 1ns / 1ps

module chacha_ctrl
    import chacha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       first_of_message,
    input  logic       out_stall,
    input  dp_status_t status,
    output logic       in_stall,
    output logic       out_valid,
    output ctrl_cmd_t  cmd
);

    state_t                 state_reg, state_next;
    logic [ROUND_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_free;
    logic                   accept;
    logic                   need_gen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign need_gen  = first_of_message || !status.ks_valid;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        accept         = 1'b0;
        cmd            = '0;
        cmd.step       = cnt_reg[1:0];
        cmd.diag       = cnt_reg[2];

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = !out_free;
                accept   = in_valid && out_free;
                if (accept)
                begin
                    if (need_gen)
                    begin
                        cmd.capture = 1'b1;
                        cmd.restart = first_of_message;
                        state_next  = ST_LOAD;
                    end
                    else
                    begin
                        cmd.direct     = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == ROUND_CNT_W'(ROUND_STEPS - 1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.final_add = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/chacha_datapath.sv @@
// chacha_datapath: configuration registers, 16-word working state, counter and output register
// depends on chacha_pkg; driven by chacha_ctrl commands
`timescale 1ns / 1ps

module chacha_datapath
    import chacha_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]             in_byte,
    input  logic                   last_of_message,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    output logic [7:0]             out_byte,
    output logic                   out_last
);

    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] init_ctr_reg;

    word_t       work_reg  [WORD_COUNT];
    word_t       work_next [WORD_COUNT];
    word_t       init_word [WORD_COUNT];
    logic [31:0] ctr_reg;
    logic [5:0]  pos_reg;
    logic        ks_valid_reg;
    logic [7:0]  hold_byte_reg;
    logic        hold_last_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    word_t       ks_word;
    logic [7:0]  ks_byte;
    logic        advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                key_reg[k] <= '0;
            end
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
            init_ctr_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KEY_0:    key_reg[0]   <= cfg_data;
                CFG_KEY_1:    key_reg[1]   <= cfg_data;
                CFG_KEY_2:    key_reg[2]   <= cfg_data;
                CFG_KEY_3:    key_reg[3]   <= cfg_data;
                CFG_NONCE_LO: nonce_lo_reg <= cfg_data;
                CFG_NONCE_HI: nonce_hi_reg <= cfg_data[31:0];
                CFG_INIT_CTR: init_ctr_reg <= cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    // initial block state
    always_comb
    begin
        init_word[0] = SIGMA_0;
        init_word[1] = SIGMA_1;
        init_word[2] = SIGMA_2;
        init_word[3] = SIGMA_3;
        for (int k = 0; k < 4; k++)
        begin
            init_word[4 + 2 * k] = key_reg[k][31:0];
            init_word[5 + 2 * k] = key_reg[k][63:32];
        end
        init_word[12] = ctr_reg;
        init_word[13] = nonce_lo_reg[31:0];
        init_word[14] = nonce_lo_reg[63:32];
        init_word[15] = nonce_hi_reg;
    end

    // working-state update: initial load, final add, or one quarter-round step on all four lanes, column or diagonal
    always_comb
    begin
        logic [1:0] jj;
        logic [3:0] ia, ib, ic, id;
        word_t      va, vb, vc, vd;
        word_t      sum_ab, sum_cd;

        for (int i = 0; i < WORD_COUNT; i++)
        begin
            work_next[i] = work_reg[i];
        end

        if (cmd.load_init)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                work_next[i] = init_word[i];
            end
        end
        else if (cmd.final_add)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                work_next[i] = work_reg[i] + init_word[i];
            end
        end
        else if (cmd.round_step)
        begin
            for (int j = 0; j < 4; j++)
            begin
                jj = 2'(j);
                ia = {2'b00, jj};
                ib = {2'b01, cmd.diag ? jj + 2'd1 : jj};
                ic = {2'b10, cmd.diag ? jj + 2'd2 : jj};
                id = {2'b11, cmd.diag ? jj + 2'd3 : jj};
                va = work_reg[ia];
                vb = work_reg[ib];
                vc = work_reg[ic];
                vd = work_reg[id];
                sum_ab = va + vb;
                sum_cd = vc + vd;
                case (cmd.step)
                    2'd0:
                    begin
                        work_next[ia] = sum_ab;
                        work_next[id] = rotl32(vd ^ sum_ab, 16);
                    end
                    2'd1:
                    begin
                        work_next[ic] = sum_cd;
                        work_next[ib] = rotl32(vb ^ sum_cd, 12);
                    end
                    2'd2:
                    begin
                        work_next[ia] = sum_ab;
                        work_next[id] = rotl32(vd ^ sum_ab, 8);
                    end
                    default:
                    begin
                        work_next[ic] = sum_cd;
                        work_next[ib] = rotl32(vb ^ sum_cd, 7);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WORD_COUNT; i++)
        begin
            work_reg[i] <= work_next[i];
        end
    end

    // keystream byte, little-endian within each word
    assign ks_word = work_reg[pos_reg[5:2]];
    assign ks_byte = 8'(ks_word >> {pos_reg[1:0], 3'b000});
    assign advance = cmd.direct || cmd.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg      <= '0;
            pos_reg      <= '0;
            ks_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.restart)
            begin
                ctr_reg      <= init_ctr_reg;
                pos_reg      <= '0;
                ks_valid_reg <= 1'b0;
            end
            else if (cmd.final_add)
            begin
                ctr_reg      <= ctr_reg + 32'd1;
                ks_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                pos_reg <= pos_reg + 6'd1;
                if (pos_reg == 6'd63)
                begin
                    ks_valid_reg <= 1'b0;
                end
            end
        end
    end

    // held item and output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hold_byte_reg <= in_byte;
            hold_last_reg <= last_of_message;
        end
        if (cmd.direct)
        begin
            out_byte_reg <= in_byte ^ ks_byte;
            out_last_reg <= last_of_message;
        end
        else if (cmd.emit)
        begin
            out_byte_reg <= hold_byte_reg ^ ks_byte;
            out_last_reg <= hold_last_reg;
        end
    end

    assign status.ks_valid = ks_valid_reg;
    assign out_byte        = out_byte_reg;
    assign out_last        = out_last_reg;

endmodule
